// ===== hdl/scheduled_soft_pwm_output_top_macros.svh =====
// Assertion macros for the scheduled soft PWM output block.
// Used by the back-end module; no other dependencies.
`ifndef SCHEDULED_SOFT_PWM_OUTPUT_TOP_MACROS_SVH
`define SCHEDULED_SOFT_PWM_OUTPUT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ssp assertion failed");
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssp implication failed");
`else
`define SSP_ASSERT(lbl, clk, rstn, prop)
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/ssp_pkg.sv =====
// Shared types, codes and helpers of the scheduled soft PWM output block.
// No dependencies.
`default_nettype none
package ssp_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam logic [15:0] LateMarginRst = 16'd50;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_QUEUE = 3'd1, OP_SET = 3'd2, OP_TAKE = 3'd3,
    OP_RELEASE = 3'd4, OP_NOP = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    FLT_NONE = 3'd0, FLT_MISSED = 3'd1, FLT_MAX_DUR = 3'd2,
    FLT_SET_QUEUE = 3'd3, FLT_PAST = 3'd4
  } fault_e;

  typedef enum logic [2:0] {
    REG_CYCLE = 3'd0, REG_MAX_HOLD = 3'd1, REG_DEFAULT_ON = 3'd2,
    REG_INITIAL_ON = 3'd3, REG_LATE_OK = 3'd4, REG_LATE_MARGIN = 3'd5
  } reg_e;

  typedef enum logic [1:0] {S_CMD, S_FIRE, S_REFILL} back_state_e;

  // mode bit positions
  localparam int unsigned MOn  = 0;
  localparam int unsigned MTog = 1;
  localparam int unsigned MChk = 2;

  typedef struct packed {
    op_e         kind;
    logic [31:0] event_time;
    logic [31:0] on_time;
    logic        level;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [31:0] data;
  } cfg_wr_t;

  // a is before b under signed wrap
  function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/ssp_in_if.sv =====
// Input request channel of the scheduled soft PWM output block.
// No dependencies.
`default_nettype none
interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] event_time;
  logic [31:0] on_time;
  logic        level;
  modport source (output valid, opcode, event_time, on_time, level, input ready);
  modport sink (input valid, opcode, event_time, on_time, level, output ready);
endinterface
`default_nettype wire

// ===== hdl/ssp_out_if.sv =====
// Result channel of the scheduled soft PWM output block.
// No dependencies.
`default_nettype none
interface ssp_out_if #(parameter int unsigned CntW = 5);
  logic               valid;
  logic               ready;
  logic               pin_level;
  logic               fault;
  logic [2:0]         fault_code;
  logic [15:0]        dropped_count;
  logic [31:0]        sched_time;
  logic [31:0]        applied_time;
  logic signed [31:0] lateness;
  logic [CntW-1:0]    queued;
  logic               held;
  modport source (output valid, pin_level, fault, fault_code, dropped_count,
                  sched_time, applied_time, lateness, queued, held,
                  input ready);
  modport sink (input valid, pin_level, fault, fault_code, dropped_count,
                sched_time, applied_time, lateness, queued, held,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/scheduled_soft_pwm_output_top.sv =====
// Top level of the scheduled soft PWM output block.
// Depends on ssp_pkg, ssp_in_if, ssp_out_if, ssp_front and ssp_back.
`default_nettype none
// One pin driven by a software PWM whose settings arrive as timed updates.
// Every accepted request (tick, queue update, immediate set, takeover,
// release) yields exactly one result carrying the pin level and status.
// Requests stream at one per cycle while the back end is idle and the
// result register is free; due timer events on a tick are handled in turn
// in the fire state, and a load event leaving two or more updates pending
// fetches the next entry from the update memory in the refill state. The
// front end holds up to two requests, and a result register parts the
// block from its consumer. Configuration writes take effect at once and
// belong in idle time. No clearing pass runs after reset.
module scheduled_soft_pwm_output_top #(
  parameter int unsigned QueueDepth = ssp_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ssp_in_if.sink           in_if,
  ssp_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import ssp_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_ready;
  cfg_wr_t cfg;

  // bundle the register write port
  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  // decode and buffer incoming requests
  ssp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // execute requests and timer events, drive results
  ssp_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cfg_i       (cfg),
    .out_if      (out_if)
  );
endmodule
`default_nettype wire

// ===== hdl/ssp_front.sv =====
// Front end: accepts requests, decodes the opcode, holds them in a two-entry queue.
// Depends on ssp_pkg and ssp_in_if.
`default_nettype none
module ssp_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ssp_in_if.sink            in_if,
  output ssp_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i
);
  import ssp_pkg::*;

  cmd_t       buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.event_time = in_if.event_time;
    dec.on_time    = in_if.on_time;
    dec.level      = in_if.level;
    case (in_if.opcode)
      3'd0:    dec.kind = OP_TICK;
      3'd1:    dec.kind = OP_QUEUE;
      3'd2:    dec.kind = OP_SET;
      3'd3:    dec.kind = OP_TAKE;
      3'd4:    dec.kind = OP_RELEASE;
      default: dec.kind = OP_NOP;
    endcase
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= dec;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ssp_back.sv =====
// Back end: PWM state, timer events, update queue and result register.
// Depends on ssp_pkg, ssp_out_if and the assertion macro header.
`default_nettype none
`include "scheduled_soft_pwm_output_top_macros.svh"
module ssp_back #(
  parameter int unsigned QueueDepth = ssp_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssp_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire ssp_pkg::cfg_wr_t cfg_i,
  ssp_out_if.source          out_if
);
  import ssp_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned FireLimit = 2 * QueueDepth + 4;
  localparam int unsigned NW = $clog2(FireLimit + 1);
  localparam logic [PW-1:0] PLast = PW'(QueueDepth - 1);
  localparam logic [CW-1:0] CDepth = CW'(QueueDepth);

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PLast) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [31:0] cycle_q, maxh_q;
  logic        def_q, late_q;
  logic [15:0] margin_q;

  // state
  back_state_e st_q, st_d;
  logic [NW-1:0] n_q, n_d;
  logic [31:0] now_q, now_d, wake_q, wake_d, onl_q, onl_d, offl_q, offl_d;
  logic [31:0] end_q, end_d, sched_q, sched_d, act_q, act_d;
  logic        armed_q, armed_d, load_q, load_d, taken_q, taken_d;
  logic        fault_q, fault_d;
  logic [2:0]  mode_q, mode_d, fkind_q, fkind_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [15:0] drops_q, drops_d;
  logic [31:0] h0t_q, h0t_d, h0o_q, h0o_d, h1t_q, h1t_d, h1o_q, h1o_d;

  logic [63:0]   mem [QueueDepth];
  logic [63:0]   rdata_q;
  logic          mem_we;
  logic [PW-1:0] mem_raddr;
  logic [63:0]   mem_wdata;

  logic    out_free, emit, flt;
  fault_e  flt_code;
  logic    exec;

  // scratch for event evaluation
  logic [31:0] t2, ev_end, ev_nw, ehold;
  logic [2:0]  fl;
  logic        onb;
  logic [CW-1:0] cnt_n;

  assign out_free    = !out_if.valid || out_if.ready;
  assign cmd_ready_o = (st_q == S_CMD) && out_free;
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign mem_raddr   = inc(inc(rp_q));

  always_comb begin
    st_d = st_q;  n_d = n_q;
    now_d = now_q; wake_d = wake_q; onl_d = onl_q; offl_d = offl_q;
    end_d = end_q; sched_d = sched_q; act_d = act_q;
    armed_d = armed_q; load_d = load_q; taken_d = taken_q;
    fault_d = fault_q; mode_d = mode_q; fkind_d = fkind_q;
    cnt_d = cnt_q; rp_d = rp_q; wp_d = wp_q; drops_d = drops_q;
    h0t_d = h0t_q; h0o_d = h0o_q; h1t_d = h1t_q; h1o_d = h1o_q;
    mem_we = 1'b0; mem_wdata = {cmd_i.event_time, cmd_i.on_time};
    emit = 1'b0; flt = 1'b0; flt_code = FLT_NONE;
    t2 = cmd_i.event_time; ev_end = '0; ev_nw = '0; fl = '0; onb = 1'b0;
    ehold = wake_q + maxh_q; cnt_n = cnt_q - 1'b1;

    case (st_q)
      S_CMD: begin
        if (exec) begin
          case (cmd_i.kind)
            OP_TICK: begin
              now_d = now_q + 1'b1;
              if (!fault_q && armed_q && !time_before(now_q + 1'b1, wake_q)) begin
                st_d = S_FIRE;
                n_d  = '0;
              end else begin
                emit = 1'b1;
              end
            end
            OP_QUEUE: begin
              emit = 1'b1;
              if (!fault_q) begin
                if (cnt_q >= CDepth) begin
                  drops_d = drops_q + 1'b1;
                end else if (!taken_q) begin
                  wp_d = inc(wp_q);
                  cnt_d = cnt_q + 1'b1;
                  mem_we = 1'b1;
                  if (cnt_q == CW'(1)) begin
                    h1t_d = cmd_i.event_time;
                    h1o_d = cmd_i.on_time;
                  end
                  if (cnt_q == '0) begin
                    if (late_q && time_before(cmd_i.event_time, now_q)) begin
                      t2 = now_q + {16'd0, margin_q};
                    end
                    mem_wdata = {t2, cmd_i.on_time};
                    h0t_d = t2;
                    h0o_d = cmd_i.on_time;
                    if (mode_q[MChk] && time_before(end_q, t2)) begin
                      flt = 1'b1; flt_code = FLT_MAX_DUR;
                    end else begin
                      end_d = t2;
                      mode_d = mode_q;
                      mode_d[MChk] = 1'b1;
                      if (!(mode_q[MTog] && armed_q && time_before(wake_q, t2))) begin
                        if (time_before(t2, now_q)) begin
                          flt = 1'b1; flt_code = FLT_PAST;
                        end else begin
                          wake_d = t2; load_d = 1'b1; armed_d = 1'b1;
                        end
                      end
                    end
                  end
                end
              end
            end
            OP_SET: begin
              emit = 1'b1;
              if (!fault_q && !taken_q) begin
                armed_d = 1'b0;
                if (cnt_q != '0) begin
                  flt = 1'b1; flt_code = FLT_SET_QUEUE;
                end else if ((cmd_i.level != def_q) && (maxh_q != '0)) begin
                  end_d = now_q + maxh_q;
                  wake_d = now_q + maxh_q;
                  load_d = 1'b1;
                  mode_d = {1'b1, 1'b0, cmd_i.level};
                  armed_d = 1'b1;
                end else begin
                  mode_d = {2'b00, cmd_i.level};
                end
              end
            end
            OP_TAKE: begin
              emit = 1'b1;
              if (!fault_q) begin
                taken_d = 1'b1; armed_d = 1'b0;
                cnt_d = '0; rp_d = '0; wp_d = '0;
                onl_d = '0; offl_d = '0; end_d = '0;
                mode_d = {2'b00, cmd_i.level};
              end
            end
            OP_RELEASE: begin
              emit = 1'b1;
              if (!fault_q) taken_d = 1'b0;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_FIRE: begin
        if ((n_q == NW'(FireLimit)) || fault_q || !armed_q ||
            time_before(now_q, wake_q)) begin
          if (out_free) begin
            emit = 1'b1;
            st_d = S_CMD;
          end
        end else begin
          n_d = n_q + 1'b1;
          if (!load_q) begin
            // toggle event
            fl = mode_q ^ 3'b001;
            ev_nw = wake_q + (fl[MOn] ? onl_q : offl_q);
            mode_d = fl;
            if (fl[MChk] && !time_before(ev_nw, end_q)) begin
              load_d = 1'b1;
              wake_d = end_q;
            end else begin
              wake_d = ev_nw;
            end
          end else if (cnt_q == '0) begin
            if ((maxh_q != '0) || !late_q) begin
              flt = 1'b1; flt_code = FLT_MISSED;
            end else begin
              armed_d = 1'b0;
            end
          end else begin
            // load event: consume the head entry
            rp_d = inc(rp_q);
            cnt_d = cnt_n;
            sched_d = h0t_q;
            act_d = now_q;
            h0t_d = h1t_q; h0o_d = h1o_q;
            if (cnt_n >= CW'(2)) st_d = S_REFILL;
            onb = (h0o_q != '0);
            fl = {2'b00, onb};
            if (!onb || (h0o_q >= cycle_q)) begin
              if ((onb != def_q) && (maxh_q != '0)) begin
                ev_end = ehold; fl[MChk] = 1'b1;
              end
            end else begin
              fl[MTog] = 1'b1;
              if (maxh_q != '0) begin
                ev_end = ehold; fl[MChk] = 1'b1;
              end
            end
            if ((cnt_n != '0) && fl[MChk] && time_before(ev_end, h1t_q)) begin
              flt = 1'b1; flt_code = FLT_MAX_DUR;
              mode_d = {2'b00, onb};
            end else begin
              if (cnt_n != '0) begin
                ev_end = h1t_q; fl[MChk] = 1'b1;
              end
              end_d = ev_end;
              mode_d = fl;
              ev_nw = wake_q + h0o_q;
              if (!fl[MTog]) begin
                if (!fl[MChk]) armed_d = 1'b0;
                else wake_d = ev_end;
              end else if (fl[MChk] && !time_before(ev_nw, ev_end)) begin
                wake_d = ev_end;
              end else begin
                load_d = 1'b0;
                wake_d = ev_nw;
                onl_d = h0o_q;
                offl_d = cycle_q - h0o_q;
              end
            end
          end
        end
      end
      S_REFILL: begin
        h1t_d = rdata_q[63:32];
        h1o_d = rdata_q[31:0];
        st_d  = S_FIRE;
      end
      default: st_d = S_CMD;
    endcase

    // shutdown: default level, drop the queue, stop the timer; a tick in
    // progress still closes through the fire state to send its result
    if (flt) begin
      if (!fault_q) fkind_d = flt_code;
      fault_d = 1'b1;
      mode_d  = {2'b00, def_q};
      cnt_d = '0; rp_d = '0; wp_d = '0;
      armed_d = 1'b0;
      if (st_d == S_REFILL) st_d = S_FIRE;
    end

    if (cfg_i.we && (cfg_i.idx == REG_INITIAL_ON) && !fault_q && !taken_q) begin
      mode_d[MOn] = cfg_i.data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= '0; maxh_q <= '0; def_q <= 1'b0;
      late_q <= 1'b0; margin_q <= LateMarginRst;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_CYCLE:       cycle_q  <= cfg_i.data;
        REG_MAX_HOLD:    maxh_q   <= cfg_i.data;
        REG_DEFAULT_ON:  def_q    <= cfg_i.data[0];
        // initial level goes straight into the mode bits
        REG_INITIAL_ON:  ;
        REG_LATE_OK:     late_q   <= cfg_i.data[0];
        REG_LATE_MARGIN: margin_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CMD; n_q <= '0;
      now_q <= '0; wake_q <= '0; onl_q <= '0; offl_q <= '0; end_q <= '0;
      sched_q <= '0; act_q <= '0;
      armed_q <= 1'b0; load_q <= 1'b0; taken_q <= 1'b0; fault_q <= 1'b0;
      mode_q <= '0; fkind_q <= '0;
      cnt_q <= '0; rp_q <= '0; wp_q <= '0; drops_q <= '0;
      out_if.valid <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d;
      now_q <= now_d; wake_q <= wake_d; onl_q <= onl_d; offl_q <= offl_d;
      end_q <= end_d; sched_q <= sched_d; act_q <= act_d;
      armed_q <= armed_d; load_q <= load_d; taken_q <= taken_d;
      fault_q <= fault_d; mode_q <= mode_d; fkind_q <= fkind_d;
      cnt_q <= cnt_d; rp_q <= rp_d; wp_q <= wp_d; drops_q <= drops_d;
      if (emit) out_if.valid <= 1'b1;
      else if (out_if.ready) out_if.valid <= 1'b0;
    end
  end

  // head entries and result payload
  always_ff @(posedge clk_i) begin
    h0t_q <= h0t_d; h0o_q <= h0o_d; h1t_q <= h1t_d; h1o_q <= h1o_d;
    if (emit) begin
      out_if.pin_level     <= mode_d[MOn];
      out_if.fault         <= fault_d;
      out_if.fault_code    <= fkind_d;
      out_if.dropped_count <= drops_d;
      out_if.sched_time    <= sched_d;
      out_if.applied_time  <= act_d;
      out_if.lateness      <= act_d - sched_d;
      out_if.queued        <= cnt_d;
      out_if.held          <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  `SSP_ASSERT(a_fault_sticky, clk_i, rst_ni, !$past(fault_q) || fault_q)
  `SSP_ASSERT_IMP(a_fault_empty, clk_i, rst_ni, fault_q, cnt_q == '0)
  `SSP_ASSERT_IMP(a_taken_empty, clk_i, rst_ni, taken_q, cnt_q == '0)
  `SSP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CDepth)
  `SSP_ASSERT_IMP(a_refill_after_load, clk_i, rst_ni, st_q == S_REFILL, $past(st_q) == S_FIRE)
endmodule
`default_nettype wire

// ===== test/scheduled_soft_pwm_output_top_test.sv =====
// Self-checking testbench for scheduled_soft_pwm_output_top.
// Depends on ssp_pkg, ssp_in_if, ssp_out_if and the block's RTL.
// Untyped requests are checked against a cycle-free model of the PWM scheduler.
`default_nettype none
module scheduled_soft_pwm_output_top_test;
  import ssp_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned FireMax = 2 * Depth + 4;
  // closing wait covers the longest burst of timer events on one tick
  localparam int unsigned SettleCycles = 2 * FireMax + 16;

  typedef struct packed {
    logic        pin;
    logic        flt;
    logic [2:0]  code;
    logic [15:0] drops;
    logic [31:0] sched;
    logic [31:0] actual;
    logic [31:0] late;
    logic [4:0]  queued;
    logic        held;
  } pin_status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] t;
    logic [31:0] on;
    logic        lvl;
    logic        typed;
    pin_status_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  ssp_in_if in_ch ();
  ssp_out_if #(.CntW(5)) out_ch ();

  scheduled_soft_pwm_output_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Scheduler model: register copies and block state
  // ---------------------------------------------------------------------
  logic [31:0] r_cycle, r_hold;
  logic        r_def, r_init, r_late;
  logic [15:0] r_margin;

  logic [31:0] clk_now, wake_t, on_len, off_len, end_t;
  logic        armed, is_load, held_pin, faulted;
  logic [2:0]  mode, fkind;
  logic [31:0] q_time [Depth];
  logic [31:0] q_on [Depth];
  logic [4:0]  q_cnt;
  logic [3:0]  rd_ptr, wr_ptr;
  logic [15:0] drop_cnt;
  logic [31:0] sched_t, actual_t;

  pin_status_t pin_status_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // signed-wrap ordering of clock times
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void trip(input fault_e code);
    if (!faulted) fkind = code;
    faulted = 1'b1;
    mode = r_def ? 3'b001 : 3'b000;
    q_cnt = '0;
    rd_ptr = '0;
    wr_ptr = '0;
    armed = 1'b0;
  endfunction

  function automatic void load_next();
    logic [31:0] t, on, e, w, nw;
    logic [2:0]  f;
    if (q_cnt == 0) begin
      if (r_hold != 0 || !r_late) trip(FLT_MISSED);
      else armed = 1'b0;
      return;
    end
    t = q_time[rd_ptr];
    on = q_on[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    q_cnt = q_cnt - 1'b1;
    f = '0;
    f[MOn] = (on != 0);
    mode[MOn] = f[MOn];
    sched_t = t;
    actual_t = clk_now;
    e = '0;
    if (!f[MOn] || on >= r_cycle) begin
      if (f[MOn] != r_def && r_hold != 0) begin
        e = wake_t + r_hold;
        f[MChk] = 1'b1;
      end
    end else begin
      f[MTog] = 1'b1;
      if (r_hold != 0) begin
        e = wake_t + r_hold;
        f[MChk] = 1'b1;
      end
    end
    if (q_cnt != 0) begin
      w = q_time[rd_ptr];
      if (f[MChk] && earlier(e, w)) begin
        trip(FLT_MAX_DUR);
        return;
      end
      e = w;
      f[MChk] = 1'b1;
    end
    end_t = e;
    mode = f;
    if (!f[MTog]) begin
      if (!f[MChk]) armed = 1'b0;
      else wake_t = e;
      return;
    end
    nw = wake_t + on;
    if (f[MChk] && !earlier(nw, e)) begin
      wake_t = e;
      return;
    end
    is_load = 1'b0;
    wake_t = nw;
    on_len = on;
    off_len = r_cycle - on;
  endfunction

  function automatic void flip_pin();
    logic [31:0] nw;
    mode[MOn] = ~mode[MOn];
    nw = wake_t + (mode[MOn] ? on_len : off_len);
    if (mode[MChk] && !earlier(nw, end_t)) begin
      is_load = 1'b1;
      nw = end_t;
    end
    wake_t = nw;
  endfunction

  function automatic void enqueue(input logic [31:0] t_in, input logic [31:0] on);
    logic [31:0] t;
    logic [3:0]  slot;
    logic [2:0]  f;
    t = t_in;
    if (q_cnt >= Depth) begin
      drop_cnt = drop_cnt + 1'b1;
      return;
    end
    if (held_pin) return;
    slot = wr_ptr;
    q_time[slot] = t;
    q_on[slot] = on;
    wr_ptr = wr_ptr + 1'b1;
    q_cnt = q_cnt + 1'b1;
    if (q_cnt != 1) return;
    if (r_late && earlier(t, clk_now)) begin
      t = clk_now + r_margin;
      q_time[slot] = t;
    end
    f = mode;
    if (f[MChk] && earlier(end_t, t)) begin
      trip(FLT_MAX_DUR);
      return;
    end
    end_t = t;
    mode = f | 3'b100;
    if (f[MTog] && armed && earlier(wake_t, t)) return;
    if (earlier(t, clk_now)) begin
      trip(FLT_PAST);
      return;
    end
    wake_t = t;
    is_load = 1'b1;
    armed = 1'b1;
  endfunction

  function automatic void set_now(input logic lvl);
    if (held_pin) return;
    armed = 1'b0;
    if (q_cnt != 0) begin
      trip(FLT_SET_QUEUE);
      return;
    end
    if (lvl != r_def && r_hold != 0) begin
      end_t = clk_now + r_hold;
      wake_t = end_t;
      is_load = 1'b1;
      mode = {1'b1, 1'b0, lvl};
      armed = 1'b1;
    end else begin
      mode = {2'b00, lvl};
    end
  endfunction

  function automatic void pwm_reset();
    r_cycle = '0; r_hold = '0; r_def = 1'b0; r_init = 1'b0; r_late = 1'b0;
    r_margin = LateMarginRst;
    clk_now = '0; wake_t = '0; on_len = '0; off_len = '0; end_t = '0;
    armed = 1'b0; is_load = 1'b0; held_pin = 1'b0; faulted = 1'b0;
    fkind = FLT_NONE;
    mode = '0;
    q_cnt = '0; rd_ptr = '0; wr_ptr = '0;
    drop_cnt = '0; sched_t = '0; actual_t = '0;
  endfunction

  function automatic void pwm_config(input reg_e idx, input logic [31:0] v);
    case (idx)
      REG_CYCLE:       r_cycle = v;
      REG_MAX_HOLD:    r_hold = v;
      REG_DEFAULT_ON:  r_def = v[0];
      REG_INITIAL_ON: begin
        r_init = v[0];
        if (!faulted && !held_pin) mode[MOn] = r_init;
      end
      REG_LATE_OK:     r_late = v[0];
      REG_LATE_MARGIN: r_margin = v[15:0];
      default: ;
    endcase
  endfunction

  // apply one request to the model and return the status that follows it
  function automatic pin_status_t pwm_step(input logic [2:0] op, input logic [31:0] t,
                                           input logic [31:0] on, input logic lvl);
    pin_status_t s;
    if (op == OP_TICK) begin
      clk_now = clk_now + 1'b1;
      for (int n = 0; n < FireMax; n++) begin
        if (faulted || !armed || earlier(clk_now, wake_t)) break;
        if (is_load) load_next();
        else flip_pin();
      end
    end else if (!faulted) begin
      case (op)
        OP_QUEUE:   enqueue(t, on);
        OP_SET:     set_now(lvl);
        OP_TAKE: begin
          held_pin = 1'b1;
          armed = 1'b0;
          q_cnt = '0; rd_ptr = '0; wr_ptr = '0;
          on_len = '0; off_len = '0; end_t = '0;
          mode = {2'b00, lvl};
        end
        OP_RELEASE: held_pin = 1'b0;
        default: ;
      endcase
    end
    s.pin = mode[MOn];
    s.flt = faulted;
    s.code = fkind;
    s.drops = drop_cnt;
    s.sched = sched_t;
    s.actual = actual_t;
    s.late = actual_t - sched_t;
    s.queued = q_cnt;
    s.held = held_pin;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: change at the falling edge, accept at the rising edge
  // ---------------------------------------------------------------------
  task automatic send_req(input logic [2:0] op, input logic [31:0] t, input logic [31:0] on,
                          input logic lvl, input bit typed, input pin_status_t want);
    int unsigned gap;
    pin_status_t s;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.event_time = t;
    in_ch.on_time = on;
    in_ch.level = lvl;
    do @(posedge clk_i); while (!in_ch.ready);
    // advance the model on acceptance; a typed row overrides its expectation
    s = pwm_step(op, t, on, lvl);
    pin_status_q.push_back(typed ? want : s);
    requests_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pwm_config(idx, v);
  endtask

  // hold until every expected status is back, then let late timer bursts finish
  task automatic drain();
    idle_input();
    wait (pin_status_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------
  initial begin
    int unsigned stall;
    pin_status_t got, want;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.pin = out_ch.pin_level;
      got.flt = out_ch.fault;
      got.code = out_ch.fault_code;
      got.drops = out_ch.dropped_count;
      got.sched = out_ch.sched_time;
      got.actual = out_ch.applied_time;
      got.late = out_ch.lateness;
      got.queued = out_ch.queued;
      got.held = out_ch.held;
      results_seen++;
      if (pin_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status at %0t", $realtime);
      end else begin
        want = pin_status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("status %0d mismatch at %0t", results_seen, $realtime);
            $display("  pin %b/%b fault %b/%b code %0d/%0d drops %0d/%0d held %b/%b",
                     want.pin, got.pin, want.flt, got.flt, want.code, got.code,
                     want.drops, got.drops, want.held, got.held);
            $display("  sched %h/%h actual %h/%h late %h/%h queued %0d/%0d",
                     want.sched, got.sched, want.actual, got.actual,
                     want.late, got.late, want.queued, got.queued);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Random traffic: mostly ticks and well-formed update streams
  // ---------------------------------------------------------------------
  task automatic random_phase(input int unsigned count, input bit allow_faults);
    int unsigned r, span;
    logic [31:0] t, on;
    pin_status_t none;
    none = '0;
    span = (r_cycle > 200 || r_cycle == 0) ? 200 : 3 * r_cycle + 20;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_req(OP_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, none);
      end else if (r < 80) begin
        t = ($urandom_range(0, 6) == 0) ? $urandom : clk_now + $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0 || r_cycle > 1000) on = $urandom;
        else on = $urandom_range(0, r_cycle + 2);
        send_req(OP_QUEUE, t, on, 1'($urandom_range(0, 1)), 1'b0, none);
      end else if (r < 85) begin
        // keep the pin out of a sticky fault unless this phase wants one
        if (allow_faults || q_cnt == 0)
          send_req(OP_SET, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, none);
        else
          send_req(OP_TICK, $urandom, $urandom, 1'b0, 1'b0, none);
      end else if (r < 90) begin
        send_req(OP_TAKE, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, none);
      end else if (r < 95) begin
        send_req(OP_RELEASE, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, none);
      end else begin
        // undefined opcodes: ignored, not counted
        send_req(3'($urandom_range(OP_NOP, 7)), $urandom, $urandom,
                 1'($urandom_range(0, 1)), 1'b0, none);
        i--;
      end
      // in a phase that allows faults, stop once mid-phase and let every result come back
      if (i == count / 2 && allow_faults) begin
        idle_input();
        wait (pin_status_q.size() == 0);
      end
    end
  endtask

  task automatic set_regs(input logic [31:0] cyc, input logic [31:0] hold, input logic def,
                          input logic init, input logic late, input logic [15:0] margin);
    write_reg(REG_CYCLE, cyc);
    write_reg(REG_MAX_HOLD, hold);
    write_reg(REG_DEFAULT_ON, 32'(def));
    write_reg(REG_INITIAL_ON, 32'(init));
    write_reg(REG_LATE_OK, 32'(late));
    write_reg(REG_LATE_MARGIN, 32'(margin));
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t dir_rows[$];
    pin_status_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TICK;
    in_ch.event_time = '0;
    in_ch.on_time = '0;
    in_ch.level = 1'b0;
    pwm_reset();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first tick after reset: everything at zero
    dir_rows.push_back('{OP_TICK, 32'd0, 32'd0, 1'b0, 1'b1, none});
    // undefined opcode: no effect, clock holds
    dir_rows.push_back('{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, none});
    dir_rows.push_back('{OP_QUEUE, 32'd5, 32'd3, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_QUEUE, 32'd20, 32'd0, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_QUEUE, 32'd30, 32'hFFFF_FFFF, 1'b0, 1'b0, none});
    for (int k = 0; k < 8; k++)
      dir_rows.push_back('{OP_TICK, 32'd0, 32'd0, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_QUEUE, 32'hFFFF_FFFF, 32'd10, 1'b1, 1'b0, none});
    // takeover discards updates and sets, release hands the pin back
    dir_rows.push_back('{OP_TAKE, 32'd0, 32'd0, 1'b1, 1'b0, none});
    dir_rows.push_back('{OP_QUEUE, 32'd100, 32'd4, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_SET, 32'd0, 32'd0, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_RELEASE, 32'd0, 32'd0, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_SET, 32'd0, 32'd0, 1'b1, 1'b0, none});
    // time in the past with the late policy: moved to now plus margin
    dir_rows.push_back('{OP_QUEUE, 32'd0, 32'd5, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_NOP, 32'd0, 32'd0, 1'b0, 1'b0, none});
    dir_rows.push_back('{OP_TICK, 32'd0, 32'd0, 1'b0, 1'b0, none});

    write_reg(REG_CYCLE, 32'd10);
    write_reg(REG_LATE_OK, 32'd1);
    foreach (dir_rows[k])
      send_req(dir_rows[k].op, dir_rows[k].t, dir_rows[k].on, dir_rows[k].lvl,
               dir_rows[k].typed, dir_rows[k].want);
    drain();

    // fault-free phases with the late policy on and the watchdog off
    set_regs(32'd10, 32'd0, 1'b0, 1'b1, 1'b1, 16'd50);
    random_phase(220, 1'b0);
    drain();
    tx_calm = 1'b1;
    set_regs(32'd0, 32'd0, 1'b1, 1'b0, 1'b1, 16'd0);
    random_phase(200, 1'b0);
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b1;
    set_regs(32'd1, 32'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF);
    random_phase(200, 1'b0);
    drain();
    rx_calm = 1'b0;
    set_regs(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 1'b1, 16'd7);
    random_phase(200, 1'b0);
    drain();
    set_regs(32'd37, 32'd0, 1'b0, 1'b0, 1'b1, 16'd3);
    random_phase(220, 1'b0);
    drain();

    // watchdog armed and the late policy off: faults become reachable
    write_reg(REG_MAX_HOLD, 32'hFFFF_FFFF);
    set_regs(32'd25, 32'd200, 1'b0, 1'b1, 1'b0, 16'd20);
    random_phase(180, 1'b1);
    drain();

    $display("ran %0d requests, %0d statuses checked, %0d mismatches", requests_sent,
             results_seen, mismatches);
    $display("covered six register settings, takeover, late updates and the fault path");
    if (mismatches == 0 && pin_status_q.size() == 0) begin
      $display("scheduled_soft_pwm_output_top_test passed");
    end else begin
      $display("scheduled_soft_pwm_output_top_test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Watchdog on the whole run
  // ---------------------------------------------------------------------
  initial begin
    #40_000_000;
    $display("scheduled_soft_pwm_output_top_test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/ssp_pkg.sv
hdl/ssp_in_if.sv
hdl/ssp_out_if.sv
hdl/ssp_front.sv
hdl/ssp_back.sv
hdl/scheduled_soft_pwm_output_top.sv
test/scheduled_soft_pwm_output_top_test.sv
